// File: sv/drfp_pkg.sv
// Package for the discovery reply field parser: item and result types, the
// service name, the model substrings and the status codes.
// Depends on nothing; every other file in sv/ imports it.
package drfp_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [63:0] SERVICE_KEY = 64'h5F79_7061_2D73_6370;

  // Three-byte model substrings in priority order, then the two-byte ones.
  localparam logic [23:0] PAT3 [9] = '{
    24'h646D37, 24'h636C35, 24'h636C33, 24'h636C31, 24'h716C35,
    24'h716C31, 24'h746635, 24'h746633, 24'h746631
  };
  localparam logic [15:0] PAT2 [3] = '{16'h7466, 16'h716C, 16'h636C};
  localparam logic [3:0] PAT_CODE [12] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd7, 4'd5, 4'd2
  };
  localparam logic [3:0] TYPE_UNKNOWN = 4'd0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SERVICE = 3'd1,
    ST_BAD_HOST   = 3'd2,
    ST_BAD_MODEL  = 3'd3,
    ST_OVERLONG   = 3'd4
  } status_t;

  // One classified byte, as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] lc_byte;
    logic       key_hit;
    logic       last;
  } item_t;

  // Result record; status sits in the lowest bits.
  typedef struct packed {
    logic [7:0]  version_length;
    logic [10:0] version_offset;
    logic [7:0]  model_length;
    logic [10:0] model_offset;
    logic [7:0]  host_length;
    logic [10:0] host_offset;
    logic [3:0]  model_type;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
    return r;
  endfunction

  function automatic logic [11:0] pattern_hits(input logic [15:0] tail,
                                               input logic [7:0] c);
    logic [11:0] h;
    logic [23:0] three;
    three = {tail, c};
    h = '0;
    for (int i = 0; i < 9; i++) h[i] = (three == PAT3[i]);
    for (int i = 0; i < 3; i++) h[9 + i] = (three[15:0] == PAT2[i]);
    return h;
  endfunction

  function automatic logic [3:0] type_code(input logic [11:0] seen);
    logic [3:0] t;
    t = TYPE_UNKNOWN;
    for (int i = 11; i >= 0; i--) begin
      if (seen[i]) t = PAT_CODE[i];
    end
    return t;
  endfunction

endpackage

// File: sv/drfp_front.sv
// Front end of the parser: accepts stream bytes, lowercases them and flags
// the byte that completes the service name. Uses drfp_pkg.
module drfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,
  input  logic           s_axis_tlast,
  input  logic           fifo_full,
  output logic           push,
  output drfp_pkg::item_t push_item
);
  import drfp_pkg::*;

  logic [63:0] recent;
  logic [63:0] recent_next;

  assign s_axis_tready = !fifo_full;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign recent_next   = {recent[55:0], s_axis_tdata};

  assign push_item.data_byte = s_axis_tdata;
  assign push_item.lc_byte   = to_lower(s_axis_tdata);
  assign push_item.key_hit   = (recent_next == SERVICE_KEY);
  assign push_item.last      = s_axis_tlast;

  // The byte history starts afresh with every datagram.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
    end else if (push) begin
      recent <= s_axis_tlast ? 64'd0 : recent_next;
    end
  end

endmodule

// File: sv/drfp_fifo.sv
// Short queue of classified bytes between the front and the back.
// Uses drfp_pkg for the item type and depth.
module drfp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  drfp_pkg::item_t       push_item,
  input  logic                  pop,
  output drfp_pkg::item_t       head,
  output drfp_pkg::fifo_status_t stat
);
  import drfp_pkg::*;

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (FIFO_PTR_W+1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/drfp_back.sv
// Back end of the parser: walks the reply layout one queued byte a cycle, but
// a last byte waits until the output result register is free. Uses drfp_pkg.
module drfp_back #(
  parameter int MAX_DATAGRAM = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  drfp_pkg::item_t        head,
  input  drfp_pkg::fifo_status_t fifo_stat,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output drfp_pkg::result_t      result
);
  import drfp_pkg::*;

  localparam int PW = $clog2(MAX_DATAGRAM + 2);
  localparam int EW = (PW + 1 > 11) ? PW + 1 : 11;

  typedef enum logic [7:0] {
    PH_SEARCH     = 8'b0000_0001,
    PH_SKIP       = 8'b0000_0010,
    PH_HOST_LEN   = 8'b0000_0100,
    PH_HOST_DATA  = 8'b0000_1000,
    PH_MODEL_LEN  = 8'b0001_0000,
    PH_MODEL_DATA = 8'b0010_0000,
    PH_VER_LEN    = 8'b0100_0000,
    PH_TAIL       = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]  left, left_next, left_dec;
  logic [10:0] offs [3];
  logic [10:0] offs_next [3];
  logic [7:0]  lens [3];
  logic [7:0]  lens_next [3];
  logic [15:0] tail, tail_next;
  logic [11:0] seen, seen_next;
  logic [EW-1:0] idx_p1;
  logic [10:0] off_here;
  logic        out_free;
  logic        ver_ok;
  result_t     res_next;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pop      = !fifo_stat.empty && (!head.last || out_free);
  assign left_dec = (left != 8'd0) ? left - 8'd1 : 8'd0;
  assign idx_p1   = EW'(pos) + EW'(1);
  assign off_here = idx_p1[10:0];

  always_comb begin
    phase_next = phase;
    pos_next   = (pos <= PW'(MAX_DATAGRAM)) ? pos + PW'(1) : pos;
    left_next  = left;
    offs_next  = offs;
    lens_next  = lens;
    tail_next  = tail;
    seen_next  = seen;
    case (phase)
      PH_SEARCH: begin
        if (head.key_hit) begin
          phase_next = PH_SKIP;
          left_next  = 8'd2;
        end
      end
      PH_SKIP: begin
        left_next = left_dec;
        if (left_dec == 8'd0) phase_next = PH_HOST_LEN;
      end
      PH_HOST_LEN, PH_MODEL_LEN, PH_VER_LEN: begin
        if (phase == PH_HOST_LEN) begin
          lens_next[0] = head.data_byte;
          offs_next[0] = off_here;
        end else if (phase == PH_MODEL_LEN) begin
          lens_next[1] = head.data_byte;
          offs_next[1] = off_here;
          tail_next    = '0;
        end else begin
          lens_next[2] = head.data_byte;
          offs_next[2] = off_here;
        end
        if (head.data_byte == 8'd0) begin
          phase_next = PH_TAIL;
          left_next  = 8'd0;
        end else begin
          left_next = head.data_byte;
          case (phase)
            PH_HOST_LEN:  phase_next = PH_HOST_DATA;
            PH_MODEL_LEN: phase_next = PH_MODEL_DATA;
            default:      phase_next = PH_TAIL;
          endcase
        end
      end
      PH_HOST_DATA, PH_MODEL_DATA: begin
        if (phase == PH_MODEL_DATA) begin
          seen_next = seen | pattern_hits(tail, head.lc_byte);
          tail_next = {tail[7:0], head.lc_byte};
        end
        left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = (phase == PH_HOST_DATA) ? PH_MODEL_LEN : PH_VER_LEN;
        end
      end
      default: begin
        left_next = left_dec;
      end
    endcase
  end

  // Result for a datagram that ends with the current byte.
  always_comb begin
    res_next = '0;
    if (pos_next > PW'(MAX_DATAGRAM)) begin
      res_next.status = ST_OVERLONG;
    end else if (phase_next == PH_SEARCH) begin
      res_next.status = ST_NO_SERVICE;
    end else if (!((phase_next == PH_MODEL_LEN || phase_next == PH_MODEL_DATA ||
                    phase_next == PH_VER_LEN || phase_next == PH_TAIL) &&
                   lens_next[0] > 8'd4)) begin
      res_next.status = ST_BAD_HOST;
    end else if (!((phase_next == PH_VER_LEN || phase_next == PH_TAIL) &&
                   lens_next[1] > 8'd1)) begin
      res_next.status = ST_BAD_MODEL;
    end else begin
      res_next.status       = ST_OK;
      res_next.model_type   = type_code(seen_next);
      res_next.host_offset  = offs_next[0];
      res_next.host_length  = lens_next[0];
      res_next.model_offset = offs_next[1];
      res_next.model_length = lens_next[1];
      if (ver_ok) begin
        res_next.version_offset = offs_next[2];
        res_next.version_length = lens_next[2];
      end
    end
  end

  assign ver_ok = (phase_next == PH_TAIL) && (lens_next[2] != 8'd0) &&
                  (left_next == 8'd0);

  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      phase <= PH_SEARCH;
      pos   <= '0;
      left  <= '0;
      tail  <= '0;
      seen  <= '0;
      for (int i = 0; i < 3; i++) begin
        offs[i] <= '0;
        lens[i] <= '0;
      end
    end else if (pop) begin
      phase <= phase_next;
      pos   <= pos_next;
      left  <= left_next;
      tail  <= tail_next;
      seen  <= seen_next;
      offs  <= offs_next;
      lens  <= lens_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop && head.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) result <= res_next;
  end

endmodule

// File: sv/discovery_reply_field_parser.sv
// Top level of the discovery reply field parser: front classifier, byte queue
// and layout walker. Uses drfp_pkg, drfp_front, drfp_fifo and drfp_back.
//
// Usage:
//   The slave stream carries one datagram byte per transaction in tdata, with
//   tlast on the final byte. Exactly one result transaction leaves on the
//   master stream for every datagram: status, model type and the offset and
//   length of the host, model and version fields (contents are not copied).
//   Bytes are taken at one per cycle while the queue is not full. The last
//   byte of a datagram, behind any bytes queued before it, has its result
//   registered when popped. The back end retires one byte per cycle;
//   only a last byte waits, and only while an earlier result is not taken.
//   While the receiver holds tready low the result stays put, the four-entry
//   queue fills and then s_axis_tready drops. Synchronous reset clears the
//   queue, the parse state and the result valid flag; the first byte can be
//   taken in the cycle after reset falls.
module discovery_reply_field_parser #(
  parameter int MAX_DATAGRAM = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_datagram
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], model_type[6:3], host_offset[17:7], host_length[25:18],
  // model_offset[36:26], model_length[44:37], version_offset[55:45],
  // version_length[63:56]
  output logic [63:0] m_axis_tdata
);
  import drfp_pkg::*;

  logic         push;
  logic         pop;
  item_t        push_item;
  item_t        head;
  fifo_status_t fifo_stat;
  result_t      result;

  drfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .fifo_full     (fifo_stat.full),
    .push          (push),
    .push_item     (push_item)
  );

  drfp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  drfp_back #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result        (result)
  );

  assign m_axis_tdata = result;

  // A failed datagram reports nothing but its status.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.status != ST_OK) |->
      (result.model_type == '0 && result.host_length == '0 &&
       result.model_length == '0 && result.version_length == '0))
    else $error("failed result carries field data");

  // A good result always has a host over four bytes and a model over one.
  a_ok_lengths: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result.status == ST_OK) |->
      (result.host_length > 8'd4 && result.model_length > 8'd1))
    else $error("ok result with short host or model");

  // The queue is never written while full nor read while empty.
  a_fifo_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && fifo_stat.full) && !(pop && fifo_stat.empty))
    else $error("byte queue overrun or underrun");

  // A new result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(pop && head.last))
    else $error("pending result overwritten");

endmodule
